FILE: rtl/fcc_pkg.sv
// ----------------------------------------------------------------------------
// fcc_pkg
// shared types and constants of the frontier cell classifier
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CELL_W  = 8;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int LIMIT_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int WIDTH_RST  = 1024;
    localparam int HEIGHT_RST = 1024;
    localparam logic [LIMIT_W-1:0] FREE_LIMIT_RST = 7'd50;
    localparam logic CONNECT_RST = 1'b1;

    localparam logic [CELL_W-1:0] UNKNOWN_CELL = 8'hFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAP_WIDTH    = 2'd0,
        REG_MAP_HEIGHT   = 2'd1,
        REG_FREE_LIMIT   = 2'd2,
        REG_CONNECTIVITY = 2'd3
    } cfg_reg_t;

    // one new window column: row y-2, row y-1, current row
    typedef struct packed {
        logic [CELL_W-1:0] up;
        logic [CELL_W-1:0] lo;
        logic [CELL_W-1:0] cur;
    } col_t;

    typedef struct packed {
        logic               shift_en;
        logic [LIMIT_W-1:0] free_limit;
        logic               eight_conn;
    } win_ctrl_t;

endpackage

FILE: rtl/frontier_cell_classifier_unit.sv
// ----------------------------------------------------------------------------
// frontier_cell_classifier_unit
// streaming frontier test on an occupancy grid in raster order
// ----------------------------------------------------------------------------
// Takes one grid cell per cycle while s_ready is high and presents, for every
// interior cell, one result once the cell below and to the right of it has
// passed through stage 1 into the result register. The rate is set by the
// line store memory, which is read and written once per cell through one
// read and one write port. While a result waits, one more cell is taken into
// stage 1 and then s_ready stays low until the result is taken.
// The line store needs no clearing after reset.
module frontier_cell_classifier_unit #(
    parameter int MAX_WIDTH  = fcc_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = fcc_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fcc_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [fcc_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [fcc_pkg::CELL_W-1:0] s_cell_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fcc_pkg::COORD_W-1:0]       m_center_x,
    output logic [fcc_pkg::COORD_W-1:0]       m_center_y,
    output logic                              m_is_frontier,
    output logic                              m_last_of_map
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LastColRst = ((fcc_pkg::WIDTH_RST > MAX_WIDTH) ?
                                 MAX_WIDTH : fcc_pkg::WIDTH_RST) - 1;
    localparam int LastRowRst = ((fcc_pkg::HEIGHT_RST > MAX_HEIGHT) ?
                                 MAX_HEIGHT : fcc_pkg::HEIGHT_RST) - 1;

    // configuration, sizes kept as clamped last index
    logic [XW-1:0]               last_col_reg;
    logic [YW-1:0]               last_row_reg;
    logic [fcc_pkg::LIMIT_W-1:0] free_limit_reg;
    logic                        connect_reg;

    // raster position of the next cell
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;

    // stage 1: cell waiting for its line store data
    logic                       s1_valid_reg;
    logic [fcc_pkg::CELL_W-1:0] s1_cell_reg;
    logic [XW-1:0]              s1_x_reg;
    logic [YW-1:0]              s1_y_reg;
    logic                       s1_emit_reg;
    logic                       s1_last_reg;

    logic [fcc_pkg::COORD_W-1:0] m_x_reg;
    logic [fcc_pkg::COORD_W-1:0] m_y_reg;
    logic                        m_frontier_reg;
    logic                        m_last_reg;
    logic                        m_valid_reg;

    logic                         accept;
    logic                         out_free;
    logic                         s1_fire;
    logic                         col_wrap;
    logic [2*fcc_pkg::CELL_W-1:0] rd_data;
    fcc_pkg::col_t                new_col;
    fcc_pkg::win_ctrl_t           win_ctrl;
    logic                         frontier;
    fcc_pkg::cfg_reg_t            cfg_sel;

    assign cfg_sel = fcc_pkg::cfg_reg_t'(cfg_wr_index);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_col_reg   <= XW'(LastColRst);
            last_row_reg   <= YW'(LastRowRst);
            free_limit_reg <= fcc_pkg::FREE_LIMIT_RST;
            connect_reg    <= fcc_pkg::CONNECT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_sel)
                fcc_pkg::REG_MAP_WIDTH: begin
                    if (cfg_wr_data < 11'd3) begin
                        last_col_reg <= XW'(2);
                    end else if (int'(cfg_wr_data) > MAX_WIDTH) begin
                        last_col_reg <= XW'(MAX_WIDTH - 1);
                    end else begin
                        last_col_reg <= XW'(cfg_wr_data - 11'd1);
                    end
                end
                fcc_pkg::REG_MAP_HEIGHT: begin
                    if (cfg_wr_data < 11'd3) begin
                        last_row_reg <= YW'(2);
                    end else if (int'(cfg_wr_data) > MAX_HEIGHT) begin
                        last_row_reg <= YW'(MAX_HEIGHT - 1);
                    end else begin
                        last_row_reg <= YW'(cfg_wr_data - 11'd1);
                    end
                end
                fcc_pkg::REG_FREE_LIMIT: begin
                    free_limit_reg <= cfg_wr_data[fcc_pkg::LIMIT_W-1:0];
                end
                fcc_pkg::REG_CONNECTIVITY: begin
                    connect_reg <= cfg_wr_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign out_free = !m_valid_reg || m_ready;
    assign s1_fire  = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    // raster counters
    always_comb begin
        col_wrap = (col_reg >= last_col_reg);
        col_next = col_wrap ? '0 : col_reg + 1'b1;
        row_next = row_reg;
        if (col_wrap) begin
            row_next = (row_reg >= last_row_reg) ? '0 : row_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_cell_reg <= s_cell_value;
            s1_x_reg    <= col_reg;
            s1_y_reg    <= row_reg;
            s1_emit_reg <= (int'(col_reg) >= 2) && (int'(row_reg) >= 2);
            s1_last_reg <= col_wrap && (row_reg >= last_row_reg);
        end
    end

    // read at transfer, write back {current row, row y-1} when stage 1 moves
    fcc_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (XW)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (rd_data),
        .wr_en   (s1_fire),
        .wr_addr (s1_x_reg),
        .wr_data ({s1_cell_reg, rd_data[2*fcc_pkg::CELL_W-1:fcc_pkg::CELL_W]})
    );

    assign new_col.up  = rd_data[fcc_pkg::CELL_W-1:0];
    assign new_col.lo  = rd_data[2*fcc_pkg::CELL_W-1:fcc_pkg::CELL_W];
    assign new_col.cur = s1_cell_reg;

    assign win_ctrl.shift_en   = s1_fire;
    assign win_ctrl.free_limit = free_limit_reg;
    assign win_ctrl.eight_conn = connect_reg;

    fcc_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (win_ctrl),
        .col_in      (new_col),
        .is_frontier (frontier)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire) begin
            m_valid_reg <= s1_emit_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_emit_reg) begin
            m_x_reg        <= fcc_pkg::COORD_W'(int'(s1_x_reg) - 1);
            m_y_reg        <= fcc_pkg::COORD_W'(int'(s1_y_reg) - 1);
            m_frontier_reg <= frontier;
            m_last_reg     <= s1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_center_x    = m_x_reg;
    assign m_center_y    = m_y_reg;
    assign m_is_frontier = m_frontier_reg;
    assign m_last_of_map = m_last_reg;

    // read and write of one line store entry never meet in one cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s1_fire) |-> (col_reg != s1_x_reg))
        else $error("line store read and write collide");

    // a stalled stage 1 keeps its cell
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_fire) |=>
            (s1_valid_reg && $stable(s1_x_reg) && $stable(s1_cell_reg)))
        else $error("stage 1 lost its cell");

    // a new result only comes from an emitting stage 1 transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(m_valid_reg) && m_valid_reg) |-> $past(s1_fire && s1_emit_reg))
        else $error("result without source cell");

endmodule

FILE: rtl/fcc_line_store.sv
// ----------------------------------------------------------------------------
// fcc_line_store
// two row stores packed in one synchronous memory, one read and one write
// port, registered read data
// ----------------------------------------------------------------------------
module fcc_line_store #(
    parameter int DEPTH = fcc_pkg::MAX_WIDTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                          aclk,
    input  logic                          rd_en,
    input  logic [AW-1:0]                 rd_addr,
    output logic [2*fcc_pkg::CELL_W-1:0]  rd_data,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [2*fcc_pkg::CELL_W-1:0]  wr_data
);

    logic [2*fcc_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/fcc_window.sv
// ----------------------------------------------------------------------------
// fcc_window
// 3x3 window columns and the frontier test on the shifted window
// ----------------------------------------------------------------------------
module fcc_window (
    input  logic                aclk,
    input  logic                aresetn,
    input  fcc_pkg::win_ctrl_t  ctrl,
    input  fcc_pkg::col_t       col_in,
    output logic                is_frontier
);

    logic [fcc_pkg::CELL_W-1:0] prev_reg [3];
    logic [fcc_pkg::CELL_W-1:0] cur_reg  [3];
    logic [fcc_pkg::CELL_W-1:0] center;
    logic                       free_c;
    logic                       unk_four;
    logic                       unk_diag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                prev_reg[i] <= '0;
                cur_reg[i]  <= '0;
            end
        end else if (ctrl.shift_en) begin
            prev_reg    <= cur_reg;
            cur_reg[0]  <= col_in.up;
            cur_reg[1]  <= col_in.lo;
            cur_reg[2]  <= col_in.cur;
        end
    end

    // after the shift: left column = prev_reg, center column = cur_reg,
    // right column = col_in
    assign center   = cur_reg[1];
    assign free_c   = !center[fcc_pkg::CELL_W-1]
                   && (center[fcc_pkg::LIMIT_W-1:0] < ctrl.free_limit);
    assign unk_four = (cur_reg[0] == fcc_pkg::UNKNOWN_CELL)
                   || (prev_reg[1] == fcc_pkg::UNKNOWN_CELL)
                   || (col_in.lo == fcc_pkg::UNKNOWN_CELL)
                   || (cur_reg[2] == fcc_pkg::UNKNOWN_CELL);
    assign unk_diag = (prev_reg[0] == fcc_pkg::UNKNOWN_CELL)
                   || (col_in.up == fcc_pkg::UNKNOWN_CELL)
                   || (prev_reg[2] == fcc_pkg::UNKNOWN_CELL)
                   || (col_in.cur == fcc_pkg::UNKNOWN_CELL);

    assign is_frontier = free_c && (unk_four || (ctrl.eight_conn && unk_diag));

endmodule

FILE: tb/frontier_cell_classifier_unit_tb.sv
// ----------------------------------------------------------------------------
// frontier_cell_classifier_unit_tb
// self-checking testbench of the streaming frontier cell classifier
// ----------------------------------------------------------------------------
// A short scripted part runs two 3x3 grids with hand-computed results, then
// random grids of small size with random threshold and neighbor set, a width
// and a height above the maximum, and size changes in the middle of a grid.
// Every accepted cell runs through a local line store and window model; each
// result transfer is compared field by field with the oldest prediction.
// Both handshakes idle at random.
module frontier_cell_classifier_unit_tb;

    import fcc_pkg::*;

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 40;
    localparam int RANDOM_TARGET = 450;

    typedef enum int {PACE_STEADY, PACE_RANDOM, PACE_SPARSE} pace_t;
    typedef enum int {STEP_WRITE, STEP_CELL} step_kind_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] center_y;
        logic               is_frontier;
        logic               last_of_map;
    } cell_verdict_t;

    typedef struct {
        step_kind_t           kind;
        cfg_reg_t             sel;
        logic [CFG_DATA_W-1:0] wdata;
        logic [CELL_W-1:0]    cval;
        bit                   typed;
        cell_verdict_t        verdict;
    } script_step_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_wr_index  = REG_MAP_WIDTH;
    logic [CFG_DATA_W-1:0]     cfg_wr_data   = '0;
    logic                      s_valid       = 1'b0;
    logic                      s_ready;
    logic signed [CELL_W-1:0]  s_cell_value  = '0;
    logic                      m_valid;
    logic                      m_ready       = 1'b0;
    logic [COORD_W-1:0]        m_center_x;
    logic [COORD_W-1:0]        m_center_y;
    logic                      m_is_frontier;
    logic                      m_last_of_map;

    // classifier model state
    logic [CELL_W-1:0]  line_above [0:MAX_W-1];
    logic [CELL_W-1:0]  line_prev  [0:MAX_W-1];
    logic [CELL_W-1:0]  win [0:8];
    int unsigned        col_pos;
    int unsigned        row_pos;
    int unsigned        map_w_reg;
    int unsigned        map_h_reg;
    logic [LIMIT_W-1:0] free_lim_reg;
    logic               eight_conn;

    cell_verdict_t pending_verdicts [$];
    script_step_t  script [$];

    pace_t       src_pace     = PACE_RANDOM;
    pace_t       sink_pace    = PACE_RANDOM;
    bit          hold_next    = 1'b0;
    int unsigned unknown_pct  = 30;
    int unsigned fed_cells    = 0;
    int unsigned mismatches   = 0;

    frontier_cell_classifier_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cell_value  (s_cell_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_center_x    (m_center_x),
        .m_center_y    (m_center_y),
        .m_is_frontier (m_is_frontier),
        .m_last_of_map (m_last_of_map)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_800_000;
        $display("frontier_cell_classifier_unit_tb: errors");
        $finish;
    end

    task automatic flag_mismatch(string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic int unsigned draw_gap(pace_t pace);
        case (pace)
            PACE_STEADY: return 0;
            PACE_RANDOM: return $urandom_range(0, 16);
            default:     return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
        endcase
    endfunction

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
        if (v < 3) return 3;
        if (v > top) return top;
        return v;
    endfunction

    // one accepted cell: shift the window, update the line stores, classify, step the raster position
    function automatic void classify_cell(input logic [CELL_W-1:0] v, output bit has_res,
                                          output cell_verdict_t res);
        int unsigned w, h, x, y;
        logic [CELL_W-1:0] from_above, from_prev;
        bit unknown_near;
        w = clamp_dim(map_w_reg, MAX_W);
        h = clamp_dim(map_h_reg, MAX_H);
        x = col_pos % MAX_W;
        y = row_pos % MAX_H;
        from_above = line_above[x];
        from_prev  = line_prev[x];
        for (int r = 0; r < 3; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
        end
        win[2] = from_above;
        win[5] = from_prev;
        win[8] = v;
        line_above[x] = from_prev;
        line_prev[x]  = v;
        has_res = (x >= 2 && y >= 2);
        res = '0;
        if (has_res) begin
            unknown_near = win[1] == UNKNOWN_CELL || win[3] == UNKNOWN_CELL ||
                           win[5] == UNKNOWN_CELL || win[7] == UNKNOWN_CELL;
            if (eight_conn)
                unknown_near = unknown_near || win[0] == UNKNOWN_CELL ||
                               win[2] == UNKNOWN_CELL || win[6] == UNKNOWN_CELL ||
                               win[8] == UNKNOWN_CELL;
            res.center_x    = x - 1;
            res.center_y    = y - 1;
            res.is_frontier = !win[4][CELL_W-1] && win[4] < free_lim_reg && unknown_near;
            res.last_of_map = (x + 1 >= w) && (y + 1 >= h);
        end
        if (x + 1 >= w) begin
            col_pos = 0;
            row_pos = (y + 1 >= h) ? 0 : y + 1;
        end else begin
            col_pos = x + 1;
            row_pos = y;
        end
    endfunction

    function automatic logic [CELL_W-1:0] pick_cell_value();
        int unsigned k;
        k = $urandom_range(0, 99);
        if (k < unknown_pct) return UNKNOWN_CELL;
        if (k < 75) return (free_lim_reg == 0) ? 8'd0 : $urandom_range(0, free_lim_reg - 1);
        if (k < 90) return $urandom_range(0, 100);
        return $urandom_range(0, 255);
    endfunction

    task automatic reg_write(cfg_reg_t sel, logic [CFG_DATA_W-1:0] d);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= sel;
        cfg_wr_data  <= d;
        @(posedge aclk);
        case (sel)
            REG_MAP_WIDTH:    map_w_reg    = d;
            REG_MAP_HEIGHT:   map_h_reg    = d;
            REG_FREE_LIMIT:   free_lim_reg = d[LIMIT_W-1:0];
            REG_CONNECTIVITY: eight_conn   = d[0];
            default: ;
        endcase
    endtask

    // stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        s_valid   <= 1'b0;
        cfg_wr_en <= 1'b0;
        do @(posedge aclk); while (pending_verdicts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_cell(logic [CELL_W-1:0] v, bit typed, cell_verdict_t typed_v);
        int unsigned gap;
        bit has_res;
        cell_verdict_t predicted;
        gap = draw_gap(src_pace);
        cfg_wr_en <= 1'b0;
        if (gap > 0 || hold_next) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
            if (hold_next)
                do @(posedge aclk); while (pending_verdicts.size() != 0);
            hold_next = 1'b0;
        end
        s_valid      <= 1'b1;
        s_cell_value <= v;
        do @(posedge aclk); while (!s_ready);
        classify_cell(v, has_res, predicted);
        if (typed)
            pending_verdicts = {pending_verdicts, typed_v};
        else if (has_res)
            pending_verdicts = {pending_verdicts, predicted};
    endtask

    task automatic set_geometry(logic [CFG_DATA_W-1:0] w_wr, logic [CFG_DATA_W-1:0] h_wr,
                                logic [LIMIT_W-1:0] lim, logic conn);
        drain_results();
        reg_write(REG_MAP_WIDTH, w_wr);
        reg_write(REG_MAP_HEIGHT, h_wr);
        reg_write(REG_FREE_LIMIT, CFG_DATA_W'(lim));
        reg_write(REG_CONNECTIVITY, CFG_DATA_W'(conn));
    endtask

    // sends random cells until n grid ends have been crossed
    task automatic feed_grids(int unsigned n);
        repeat (n) begin
            do begin
                hold_next = ($urandom_range(0, 79) == 0);
                send_cell(pick_cell_value(), 1'b0, '0);
                fed_cells++;
            end while (col_pos != 0 || row_pos != 0);
        end
    endtask

    task automatic add_write(cfg_reg_t sel, int unsigned d);
        script_step_t st;
        st = '{kind: STEP_WRITE, sel: sel, wdata: d, cval: '0, typed: 1'b0, verdict: '0};
        script = {script, st};
    endtask

    task automatic add_cell(logic [CELL_W-1:0] v, bit typed = 1'b0,
                            cell_verdict_t verdict = '0);
        script_step_t st;
        st = '{kind: STEP_CELL, sel: REG_MAP_WIDTH, wdata: '0, cval: v, typed: typed,
               verdict: verdict};
        script = {script, st};
    endtask

    // result side
    initial begin : result_sink
        int unsigned gap;
        cell_verdict_t want;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = draw_gap(sink_pace);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            if (pending_verdicts.size() == 0) begin
                flag_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                        m_center_x, m_center_y));
            end else begin
                want = pending_verdicts.pop_front();
                if (m_center_x !== want.center_x)
                    flag_mismatch($sformatf("center_x got %0d expected %0d",
                                            m_center_x, want.center_x));
                if (m_center_y !== want.center_y)
                    flag_mismatch($sformatf("center_y got %0d expected %0d",
                                            m_center_y, want.center_y));
                if (m_is_frontier !== want.is_frontier)
                    flag_mismatch($sformatf("is_frontier got %b expected %b at (%0d,%0d)",
                                            m_is_frontier, want.is_frontier,
                                            want.center_x, want.center_y));
                if (m_last_of_map !== want.last_of_map)
                    flag_mismatch($sformatf("last_of_map got %b expected %b at (%0d,%0d)",
                                            m_last_of_map, want.last_of_map,
                                            want.center_x, want.center_y));
            end
        end
    end

    // stimulus
    initial begin : stimulus
        bit in_writes;
        logic [CFG_DATA_W-1:0] w_wr, h_wr;
        logic [LIMIT_W-1:0] lim;

        for (int i = 0; i < MAX_W; i++) begin
            line_above[i] = '0;
            line_prev[i]  = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        col_pos      = 0;
        row_pos      = 0;
        map_w_reg    = WIDTH_RST;
        map_h_reg    = HEIGHT_RST;
        free_lim_reg = FREE_LIMIT_RST;
        eight_conn   = CONNECT_RST;

        // 3x3 grid: free center, unknown only on a diagonal, 8 then 4 neighbors
        add_write(REG_MAP_WIDTH, 3);
        add_write(REG_MAP_HEIGHT, 3);
        add_write(REG_FREE_LIMIT, 50);
        add_write(REG_CONNECTIVITY, 1);
        add_cell(-1); add_cell(127); add_cell(-128);
        add_cell(0);  add_cell(49);  add_cell(0);
        add_cell(100); add_cell(50);
        add_cell(0, 1'b1, '{center_x: 1, center_y: 1, is_frontier: 1, last_of_map: 1});
        add_write(REG_CONNECTIVITY, 0);
        add_cell(-1); add_cell(127); add_cell(-128);
        add_cell(0);  add_cell(49);  add_cell(0);
        add_cell(100); add_cell(50);
        add_cell(0, 1'b1, '{center_x: 1, center_y: 1, is_frontier: 0, last_of_map: 1});

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        in_writes = 1'b0;
        foreach (script[i]) begin
            if (script[i].kind == STEP_WRITE) begin
                if (!in_writes) drain_results();
                in_writes = 1'b1;
                reg_write(script[i].sel, script[i].wdata);
            end else begin
                in_writes = 1'b0;
                send_cell(script[i].cval, script[i].typed, script[i].verdict);
            end
        end

        // random small grids, sizes sometimes below the minimum
        while (fed_cells < RANDOM_TARGET) begin
            w_wr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            h_wr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            case ($urandom_range(0, 4))
                0:       lim = 0;
                1:       lim = 127;
                2:       lim = 50;
                default: lim = $urandom_range(1, 126);
            endcase
            src_pace    = pace_t'($urandom_range(0, 2));
            sink_pace   = pace_t'($urandom_range(0, 2));
            unknown_pct = $urandom_range(5, 45);
            set_geometry(w_wr, h_wr, lim, $urandom_range(0, 1));
            feed_grids($urandom_range(1, 3));
        end

        // width above the maximum: part of a first row, then a narrow width
        src_pace  = PACE_SPARSE;
        sink_pace = PACE_SPARSE;
        set_geometry(11'h7FF, 11'd0, $urandom_range(0, 127), $urandom_range(0, 1));
        repeat (20) send_cell(pick_cell_value(), 1'b0, '0);
        drain_results();
        reg_write(REG_MAP_WIDTH, 11'd5);
        feed_grids(1);

        // height above the maximum: twenty rows, then a short height
        set_geometry(11'd1, 11'h7FF, $urandom_range(0, 127), $urandom_range(0, 1));
        repeat (60) send_cell(pick_cell_value(), 1'b0, '0);
        drain_results();
        reg_write(REG_MAP_HEIGHT, 11'd4);
        feed_grids(1);

        // shrink width and height while inside row 3, column 4
        src_pace  = PACE_RANDOM;
        sink_pace = PACE_RANDOM;
        set_geometry(11'd10, 11'd6, $urandom_range(20, 100), 1'b1);
        repeat (34) send_cell(pick_cell_value(), 1'b0, '0);
        drain_results();
        reg_write(REG_MAP_WIDTH, 11'd4);
        reg_write(REG_MAP_HEIGHT, 11'd3);
        feed_grids(2);

        sink_pace = PACE_STEADY;
        drain_results();
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("frontier_cell_classifier_unit_tb: clean");
        else
            $display("frontier_cell_classifier_unit_tb: errors");
        $finish;
    end

endmodule
